### src/rcdf_pkg.sv
// Shared types, constants and the CRC-8 step function for the frame deframer.
package rcdf_pkg;

    // Largest payload a frame may carry
    localparam int PAYLOAD_BYTES = 64;

    // Length byte limits: length counts type byte, payload and CRC byte
    localparam int LEN_W = $clog2(PAYLOAD_BYTES + 3);
    localparam logic [7:0] LEN_MIN = 8'd3;
    localparam logic [7:0] LEN_MAX = 8'(PAYLOAD_BYTES + 2);

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 3;

    // CRC-8 polynomial and top bit
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST      = 3'd0,
        CFG_SYNC_SECOND     = 3'd1,
        CFG_TYPE_CHANNELS_A = 3'd2,
        CFG_TYPE_CHANNELS_B = 3'd3,
        CFG_TYPE_IGNORED    = 3'd4
    } cfg_index_t;

    // Parser states
    typedef enum logic [2:0] {
        ST_UNSYNCED = 3'd0,
        ST_SYNC1    = 3'd1,
        ST_SYNC2    = 3'd2,
        ST_LEN      = 3'd3,
        ST_PAYLOAD  = 3'd4,
        ST_CRC      = 3'd5
    } parse_state_t;

    // Per-byte status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_IN_PROGRESS = 3'd0,
        STAT_FRAME_OK    = 3'd1,
        STAT_UNKNOWN     = 3'd2,
        STAT_UNSYNCED    = 3'd3,
        STAT_CRC_ERROR   = 3'd4,
        STAT_IGNORED     = 3'd5
    } status_t;

    // Configuration register set
    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] type_channels_a;
        logic [BYTE_W-1:0] type_channels_b;
        logic [BYTE_W-1:0] type_ignored;
    } cfg_t;

    // One result item
    typedef struct packed {
        status_t           status;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic [BYTE_W-1:0] frame_type;
    } result_t;

    // Bytewise CRC-8 update, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 8'd0)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### src/rcdf_if.sv
// Valid/ready channel interfaces for received bytes and result items.
interface rcdf_in_if;
    logic                       valid;
    logic                       ready;
    logic [rcdf_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcdf_out_if;
    logic                        valid;
    logic                        ready;
    logic [rcdf_pkg::STAT_W-1:0] status;
    logic                        payload_valid;
    logic [rcdf_pkg::BYTE_W-1:0] payload_byte;
    logic [rcdf_pkg::IDX_W-1:0]  payload_index;
    logic [rcdf_pkg::BYTE_W-1:0] frame_type;

    modport source (output valid, output status, output payload_valid, output payload_byte,
                    output payload_index, output frame_type, input ready);
    modport sink   (input valid, input status, input payload_valid, input payload_byte,
                    input payload_index, input frame_type, output ready);
endinterface

### src/rc_frame_deframer_crc8_core.sv
// Top level: input byte register, frame parser and result register.
// A byte accepted into the input register moves through the parser into the result
// register when that is free or draining. Throughput: one byte per cycle while the
// result channel is ready; CRC-8 and parse-state update between them are combinational.
// Reset: rst_n clears parse state, pipeline valid bits and loads register defaults.
module rc_frame_deframer_crc8_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rcdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcdf_pkg::CFG_W-1:0]     cfg_data,
    rcdf_in_if.sink                        rx_ch,
    rcdf_out_if.source                     res_ch
);

    rcdf_pkg::cfg_t    cfg;
    rcdf_pkg::result_t result;
    rcdf_pkg::result_t res_reg;

    logic                        in_valid_reg, in_valid_next;
    logic [rcdf_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        advance;
    logic                        take;

    rcdf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcdf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Move the held byte forward when the result register is free or draining
    assign advance     = in_valid_reg && (!out_valid_reg || res_ch.ready);
    assign rx_ch.ready = !in_valid_reg || advance;
    assign take        = rx_ch.valid && rx_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (res_ch.ready)
            out_valid_next = 1'b0;
    end

    // Hold pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= rx_ch.rx_byte;
        if (advance)
            res_reg <= result;
    end

    assign res_ch.valid         = out_valid_reg;
    assign res_ch.status        = res_reg.status;
    assign res_ch.payload_valid = res_reg.payload_valid;
    assign res_ch.payload_byte  = res_reg.payload_byte;
    assign res_ch.payload_index = res_reg.payload_index;
    assign res_ch.frame_type    = res_reg.frame_type;

endmodule

### src/rcdf_cfg_regs.sv
// Configuration register file with write port and reset values.
module rcdf_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rcdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcdf_pkg::CFG_W-1:0]     cfg_data,
    output rcdf_pkg::cfg_t                 cfg
);

    rcdf_pkg::cfg_t cfg_reg;
    rcdf_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes leave the registers alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rcdf_pkg::CFG_SYNC_FIRST:      cfg_next.sync_first      = cfg_data;
                rcdf_pkg::CFG_SYNC_SECOND:     cfg_next.sync_second     = cfg_data;
                rcdf_pkg::CFG_TYPE_CHANNELS_A: cfg_next.type_channels_a = cfg_data;
                rcdf_pkg::CFG_TYPE_CHANNELS_B: cfg_next.type_channels_b = cfg_data;
                rcdf_pkg::CFG_TYPE_IGNORED:    cfg_next.type_ignored    = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first      <= 8'h55;
            cfg_reg.sync_second     <= 8'h55;
            cfg_reg.type_channels_a <= 8'h00;
            cfg_reg.type_channels_b <= 8'h01;
            cfg_reg.type_ignored    <= 8'h02;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/rcdf_parser.sv
// Frame parse state machine with running CRC-8; one byte per step.
module rcdf_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [rcdf_pkg::BYTE_W-1:0] rx_byte,
    input  rcdf_pkg::cfg_t              cfg,
    output rcdf_pkg::result_t           result
);

    localparam int LW = rcdf_pkg::LEN_W;

    rcdf_pkg::parse_state_t state_reg, state_next;
    logic [LW-1:0]          length_reg, length_next;
    logic [LW-1:0]          count_reg, count_next;
    logic [7:0]             type_reg, type_next;
    logic [7:0]             crc_reg, crc_next;

    logic [7:0]             crc_upd;
    logic [LW-1:0]          count_inc;
    logic [LW-1:0]          count_dec;
    logic [LW:0]            count_end;

    assign crc_upd   = rcdf_pkg::crc8_update(crc_reg, rx_byte);
    assign count_inc = count_reg + LW'(1);
    assign count_dec = count_reg - LW'(1);
    assign count_end = {1'b0, count_inc} + (LW+1)'(1);

    // Next state and the result for the current byte
    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        count_next  = count_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;

        result.status        = rcdf_pkg::STAT_IN_PROGRESS;
        result.payload_valid = 1'b0;
        result.payload_byte  = '0;
        result.payload_index = '0;
        result.frame_type    = '0;

        case (state_reg)
            rcdf_pkg::ST_SYNC1:
            begin
                if (rx_byte == cfg.sync_second)
                    state_next = rcdf_pkg::ST_SYNC2;
                else
                    state_next = rcdf_pkg::ST_UNSYNCED;
            end
            rcdf_pkg::ST_SYNC2:
            begin
                // Accept the length byte only inside the legal range
                if (rx_byte inside {[rcdf_pkg::LEN_MIN:rcdf_pkg::LEN_MAX]})
                begin
                    length_next = rx_byte[LW-1:0];
                    count_next  = '0;
                    crc_next    = rcdf_pkg::crc8_update(8'h00, rx_byte);
                    state_next  = rcdf_pkg::ST_LEN;
                end
                else
                begin
                    state_next = rcdf_pkg::ST_UNSYNCED;
                end
            end
            rcdf_pkg::ST_LEN:
            begin
                type_next         = rx_byte;
                count_next        = LW'(1);
                crc_next          = crc_upd;
                result.frame_type = rx_byte;
                state_next        = rcdf_pkg::ST_PAYLOAD;
            end
            rcdf_pkg::ST_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = count_dec[rcdf_pkg::IDX_W-1:0];
                result.frame_type    = type_reg;
                crc_next             = crc_upd;
                count_next           = count_inc;
                if (count_end >= {1'b0, length_reg})
                    state_next = rcdf_pkg::ST_CRC;
            end
            rcdf_pkg::ST_CRC:
            begin
                result.frame_type = type_reg;
                count_next        = count_inc;
                // Check the CRC byte, then classify the frame type
                if (rx_byte == crc_reg)
                begin
                    if (type_reg == cfg.type_channels_a || type_reg == cfg.type_channels_b)
                        result.status = rcdf_pkg::STAT_FRAME_OK;
                    else if (type_reg == cfg.type_ignored)
                        result.status = rcdf_pkg::STAT_IGNORED;
                    else
                        result.status = rcdf_pkg::STAT_UNKNOWN;
                end
                else
                begin
                    result.status = rcdf_pkg::STAT_CRC_ERROR;
                end
                state_next = rcdf_pkg::ST_UNSYNCED;
            end
            default:
            begin
                // Hunt for the first sync byte
                if (rx_byte == cfg.sync_first)
                    state_next = rcdf_pkg::ST_SYNC1;
                else
                    result.status = rcdf_pkg::STAT_UNSYNCED;
            end
        endcase
    end

    // Advance parse state once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcdf_pkg::ST_UNSYNCED;
            length_reg <= '0;
            count_reg  <= '0;
            type_reg   <= '0;
            crc_reg    <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            type_reg   <= type_next;
            crc_reg    <= crc_next;
        end
    end

endmodule
